[hdl/button_event_tracker_core_assert.svh]
// ---------------------------------------------------------------------------
// Button event tracker assertion macros
// Clocked assertion wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef BUTTON_EVENT_TRACKER_CORE_ASSERT_SVH
`define BUTTON_EVENT_TRACKER_CORE_ASSERT_SVH

// Check a property on every rising edge, outside reset.
`define BET_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define BET_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/bet_pkg.sv]
// ---------------------------------------------------------------------------
// Button event tracker package
// Shared constants, status and event codes, register indexes.
// ---------------------------------------------------------------------------
package bet_pkg;

	localparam int NUM_BUTTONS = 8;
	localparam int BUTTON_W    = 3;
	localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int SEL_W       = (IDX_W > BUTTON_W) ? IDX_W : BUTTON_W;
	localparam int REG_W       = 8;
	localparam int CNT_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int TDATA_W     = 8;

	localparam logic [REG_W-1:0] ENABLE_RST    = 8'h00;
	localparam logic [REG_W-1:0] IDLE_RST      = 8'hFF;
	localparam logic [REG_W-1:0] THRESHOLD_RST = 8'd20;
	localparam logic [CNT_W-1:0] CNT_MAX       = 8'hFF;

	typedef enum logic [2:0] {
		ST_FREE    = 3'd0,
		ST_PRESS   = 3'd1,
		ST_DOWN    = 3'd2,
		ST_RELEASE = 3'd3,
		ST_HOLD    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2,
		EV_HOLD    = 2'd3
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE    = 2'd0,
		CFG_IDLE      = 2'd1,
		CFG_THRESHOLD = 2'd2
	} cfg_idx_t;

endpackage

[hdl/button_event_tracker_core.sv]
// ---------------------------------------------------------------------------
// Button event tracker core
// Per-button press/down/release/hold status tracking from pin samples.
// ---------------------------------------------------------------------------
// Each input transfer is one polling sample of one button (index and pin
// level); each one yields exactly one result transfer with the button index,
// the event (none, press, release, hold) and the button's new status. The
// block takes one sample per clock cycle while the result stream is not
// stalled; each sample is held in the input register and its result in the
// result register. The rate is set by the per-button status and hold-counter
// register file, which is read, updated and written back between those two
// registers, so consecutive samples of the same button see each other's
// updates. While a result waits on a stalled consumer, the input register
// still takes one more sample; the sample after that waits until the result
// drains. Configuration writes take effect on the cycle after the write
// transfer and must be done while no sample is in flight. A button is up
// when its pin level equals its idle level bit; a disabled button keeps its
// status and reports no event.
// ---------------------------------------------------------------------------
module button_event_tracker_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// sample stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bet_pkg::TDATA_W-1:0]    s_tdata,   // [2:0] button, [3] pin_level
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bet_pkg::TDATA_W-1:0]    m_tdata,   // [2:0] event_button, [4:3] event_code,
	                                                  // [7:5] new_status
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bet_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bet_pkg::REG_W-1:0]      cfg_data
);

	// configuration registers
	logic [bet_pkg::REG_W-1:0] enable_q;
	logic [bet_pkg::REG_W-1:0] idle_q;
	logic [bet_pkg::REG_W-1:0] threshold_q;

	// per-button state
	bet_pkg::status_t         status_q  [bet_pkg::NUM_BUTTONS];
	logic [bet_pkg::CNT_W-1:0] counter_q [bet_pkg::NUM_BUTTONS];

	// input register
	logic                          valid_s1;
	logic [bet_pkg::BUTTON_W-1:0]  button_s1;
	logic                          pin_s1;

	// result register
	logic                          valid_s2;
	logic [bet_pkg::BUTTON_W-1:0]  event_button_s2;
	bet_pkg::event_t               event_code_s2;
	bet_pkg::status_t              new_status_s2;

	// update logic
	logic                          advance;
	logic [bet_pkg::SEL_W-1:0]     sel_wide;
	logic [bet_pkg::IDX_W-1:0]     sel;
	logic                          in_range;
	logic                          enabled;
	logic                          up;
	logic                          write_en;
	bet_pkg::status_t              rd_status;
	logic [bet_pkg::CNT_W-1:0]     rd_count;
	logic [bet_pkg::CNT_W-1:0]     inc_count;
	bet_pkg::status_t              nxt_status;
	logic [bet_pkg::CNT_W-1:0]     nxt_count;
	bet_pkg::status_t              res_status;
	bet_pkg::event_t               res_event;

	// ---------------- handshakes ----------------
	// Move the sample into the result register whenever that register is
	// empty or being drained; the input register refills in the same cycle.
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign m_tvalid = valid_s2;
	assign m_tdata  = {new_status_s2, event_code_s2, event_button_s2};

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= bet_pkg::ENABLE_RST;
			idle_q      <= bet_pkg::IDLE_RST;
			threshold_q <= bet_pkg::THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			// writes to an index past the register list are dropped
			unique case (bet_pkg::cfg_idx_t'(cfg_index))
				bet_pkg::CFG_ENABLE:    enable_q    <= cfg_data;
				bet_pkg::CFG_IDLE:      idle_q      <= cfg_data;
				bet_pkg::CFG_THRESHOLD: threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			button_s1 <= s_tdata[bet_pkg::BUTTON_W-1:0];
			pin_s1    <= s_tdata[bet_pkg::BUTTON_W];
		end
	end

	// ---------------- state lookup ----------------
	assign sel_wide  = bet_pkg::SEL_W'(button_s1);
	assign sel       = sel_wide[bet_pkg::IDX_W-1:0];
	assign in_range  = int'(button_s1) < bet_pkg::NUM_BUTTONS;
	assign enabled   = enable_q[button_s1];
	// up means the pin sits at the button's configured idle level
	assign up        = (pin_s1 == idle_q[button_s1]);
	assign rd_status = status_q[sel];
	assign rd_count  = counter_q[sel];
	// saturate the hold counter at its top value
	assign inc_count = (rd_count == bet_pkg::CNT_MAX) ? rd_count
	                                                  : rd_count + bet_pkg::CNT_W'(1);
	assign write_en  = advance && in_range && enabled;

	// ---------------- next status ----------------
	always_comb begin
		nxt_status = rd_status;
		nxt_count  = rd_count;
		if (up) begin
			unique case (rd_status)
				bet_pkg::ST_FREE:    nxt_status = bet_pkg::ST_FREE;
				bet_pkg::ST_PRESS:   nxt_status = bet_pkg::ST_FREE;
				bet_pkg::ST_RELEASE: nxt_status = bet_pkg::ST_FREE;
				bet_pkg::ST_DOWN:    nxt_status = bet_pkg::ST_RELEASE;
				bet_pkg::ST_HOLD:    nxt_status = bet_pkg::ST_RELEASE;
				default:             nxt_status = rd_status;
			endcase
		end else begin
			unique case (rd_status)
				bet_pkg::ST_FREE:    nxt_status = bet_pkg::ST_PRESS;
				bet_pkg::ST_PRESS: begin
					nxt_status = bet_pkg::ST_DOWN;
					nxt_count  = '0;
				end
				bet_pkg::ST_DOWN: begin
					// count this tick, then compare the updated count
					nxt_count = inc_count;
					if (inc_count >= threshold_q) begin
						nxt_status = bet_pkg::ST_HOLD;
					end
				end
				bet_pkg::ST_RELEASE: nxt_status = bet_pkg::ST_FREE;
				bet_pkg::ST_HOLD:    nxt_status = bet_pkg::ST_HOLD;
				default:             nxt_status = rd_status;
			endcase
		end
	end

	// ---------------- result ----------------
	always_comb begin
		// a button past the count reports free, a disabled one its kept status
		priority if (!in_range) begin
			res_status = bet_pkg::ST_FREE;
		end else if (!enabled) begin
			res_status = rd_status;
		end else begin
			res_status = nxt_status;
		end
	end

	always_comb begin
		if (in_range && enabled) begin
			unique case (res_status)
				bet_pkg::ST_PRESS:   res_event = bet_pkg::EV_PRESS;
				bet_pkg::ST_RELEASE: res_event = bet_pkg::EV_RELEASE;
				bet_pkg::ST_HOLD:    res_event = bet_pkg::EV_HOLD;
				default:             res_event = bet_pkg::EV_NONE;
			endcase
		end else begin
			res_event = bet_pkg::EV_NONE;
		end
	end

	// ---------------- state write-back ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < bet_pkg::NUM_BUTTONS; b++) begin
				status_q[b]  <= bet_pkg::ST_FREE;
				counter_q[b] <= '0;
			end
		end else if (write_en) begin
			status_q[sel]  <= nxt_status;
			counter_q[sel] <= nxt_count;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_button_s2 <= button_s1;
			event_code_s2   <= res_event;
			new_status_s2   <= res_status;
		end
	end

endmodule

[hdl/bet_checker.sv]
// ---------------------------------------------------------------------------
// Button event tracker port checker
// Port-level assertions, bound to the core.
// ---------------------------------------------------------------------------
`include "button_event_tracker_core_assert.svh"

module bet_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [bet_pkg::TDATA_W-1:0]    m_tdata,
	input logic                           cfg_valid,
	input logic                           cfg_ready
);

	logic [1:0] code;
	logic [2:0] status;

	assign code   = m_tdata[4:3];
	assign status = m_tdata[7:5];

	// a stalled result holds
	`BET_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

	// a reported event always matches the status it came from
	`BET_ASSERT(a_event_status, m_tvalid |-> (code == bet_pkg::EV_NONE) || (code == bet_pkg::EV_PRESS && status == bet_pkg::ST_PRESS) || (code == bet_pkg::EV_RELEASE && status == bet_pkg::ST_RELEASE) || (code == bet_pkg::EV_HOLD && status == bet_pkg::ST_HOLD), "event does not match status")

	// with the result register empty the input side never stalls
	`BET_ASSERT(a_empty_ready, !m_tvalid |-> s_tready, "input stalled with empty output")

	// configuration writes are never back-pressured
	`BET_ASSERT_ALWAYS(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration write stalled")

endmodule

bind button_event_tracker_core bet_checker u_bet_checker (.*);
